>>> src/llh_pkg.sv
// Shared types and constants for the log/linear histogram engine.
package llh_pkg;

  localparam int NUM_BUCKETS = 64;
  localparam int COUNT_BITS  = 32;
  localparam int IDX_BITS    = $clog2(NUM_BUCKETS);

  // Fixed field widths of the transactions and registers.
  localparam int SAMPLE_W = 48;
  localparam int BUCKET_W = 6;
  localparam int OUT_CNT_W = 32;
  localparam int CFG_IDX_W = 2;
  localparam int STEP_W   = $clog2(SAMPLE_W);

  // Request function codes.
  localparam logic FUNC_RECORD = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  // Binning modes.
  localparam logic MODE_LOG2   = 1'b0;
  localparam logic MODE_LINEAR = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LIMIT  = 2'd2;

  localparam logic [SAMPLE_W-1:0] RESET_BUCKET_WIDTH = 48'd1;
  localparam logic [SAMPLE_W-1:0] RESET_RANGE_LIMIT  = 48'd512;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic start;
  } llh_unit_ctl_t;

  typedef struct packed {
    logic                done;
    logic [SAMPLE_W-1:0] quotient;
    logic [BUCKET_W-1:0] log_bucket;
    logic                log_ok;
  } llh_unit_sts_t;

  typedef struct packed {
    logic                  rd_en;
    logic [IDX_BITS-1:0]   rd_addr;
    logic                  wr_en;
    logic [IDX_BITS-1:0]   wr_addr;
    logic [COUNT_BITS-1:0] wr_data;
  } llh_store_req_t;

endpackage

>>> src/llh_if.sv
// Request and response channel interfaces of the histogram engine.
interface llh_req_if import llh_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                func;
  logic [SAMPLE_W-1:0] sample;
  logic [BUCKET_W-1:0] read_index;

  modport source (output valid, func, sample, read_index, input ready);
  modport sink (input valid, func, sample, read_index, output ready);
endinterface

interface llh_rsp_if import llh_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 counted;
  logic [BUCKET_W-1:0]  bucket;
  logic [OUT_CNT_W-1:0] bucket_count;

  modport source (output valid, counted, bucket, bucket_count, input ready);
  modport sink (input valid, counted, bucket, bucket_count, output ready);
endinterface

>>> src/log_linear_histogram.sv
// Top level of the log/linear histogram engine: sequencer, config and output register.
//
// The req channel carries one transaction per operation: func selects record (bin the
// sample and bump its bucket counter) or read (return the count of read_index). Every
// request produces exactly one transaction on the rsp channel with counted, bucket and
// bucket_count. Dropped samples answer with all fields zero and change nothing.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must write it
// only while the engine is idle, which the block itself does not enforce: index 0
// bin_mode, 1 bucket_width, 2 range_limit; other indexes are ignored. A record runs the
// shared bit-serial unit, one step per sample bit (48 steps), for both the leading-one
// search and the linear division. Unless the sample is dropped, a counter read and a
// write-back follow; then the output register loads. A read fetches its counter as it
// is accepted, then loads the output register. One request is in flight at a time;
// req.ready is high only while the sequencer is idle and returns on the edge that loads
// the output register. A new request may be accepted while the previous response still
// waits; if the receiver stalls, the finished result is held until the register frees
// up. Reset restores the register defaults (power-of-two mode, width 1, limit 512) and
// clears all 64 bucket counters at once through per-entry valid bits, so no clearing
// pass is needed.
module log_linear_histogram import llh_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SAMPLE_W-1:0]  cfg_data,
  llh_req_if.sink              req,
  llh_rsp_if.source            rsp
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_FETCH = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  // Configuration registers.
  logic                bin_mode;
  logic [SAMPLE_W-1:0] bucket_width;
  logic [SAMPLE_W-1:0] range_limit;

  // Sequencer state and the operation in flight.
  logic [1:0]          state;
  logic                is_read;
  logic                read_oob;
  logic                lin_mode;
  logic                lin_pre_ok;
  logic [BUCKET_W-1:0] cur_bucket;

  // Finished result and output register.
  logic                  res_counted;
  logic [BUCKET_W-1:0]   res_bucket;
  logic [OUT_CNT_W-1:0]  res_count;
  logic                  out_valid;
  logic                  out_counted;
  logic [BUCKET_W-1:0]   out_bucket;
  logic [OUT_CNT_W-1:0]  out_count;

  llh_unit_ctl_t         unit_ctl;
  llh_unit_sts_t         unit_sts;
  llh_store_req_t        store_req;
  logic [COUNT_BITS-1:0] rd_data;

  logic                  accept;
  logic                  rec_ok;
  logic [BUCKET_W-1:0]   rec_bucket;
  logic [COUNT_BITS-1:0] cnt_next;
  logic                  out_free;

  llh_scan_div u_scan_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (unit_ctl),
    .dividend (req.sample),
    .divisor  (bucket_width),
    .limit    (range_limit),
    .sts      (unit_sts)
  );

  llh_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (store_req),
    .rd_data (rd_data)
  );

  always_comb begin
    accept         = req.valid && (state == S_IDLE);
    unit_ctl.start = accept && (req.func == FUNC_RECORD);

    // In linear mode the quotient must also land inside the store.
    if (lin_mode == MODE_LINEAR) begin
      rec_ok     = lin_pre_ok && (unit_sts.quotient < SAMPLE_W'(NUM_BUCKETS));
      rec_bucket = unit_sts.quotient[BUCKET_W-1:0];
    end else begin
      rec_ok     = unit_sts.log_ok;
      rec_bucket = unit_sts.log_bucket;
    end

    store_req.rd_en = (accept && (req.func == FUNC_READ)) ||
                      ((state == S_RUN) && unit_sts.done && rec_ok);
    store_req.rd_addr = (state == S_IDLE) ? req.read_index[IDX_BITS-1:0]
                                          : rec_bucket[IDX_BITS-1:0];

    // Saturating increment of the fetched counter.
    cnt_next = (rd_data == COUNT_MAX) ? rd_data : rd_data + 1'b1;

    store_req.wr_en   = (state == S_FETCH) && !is_read;
    store_req.wr_addr = cur_bucket[IDX_BITS-1:0];
    store_req.wr_data = cnt_next;

    out_free = !out_valid || rsp.ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_mode     <= MODE_LOG2;
      bucket_width <= RESET_BUCKET_WIDTH;
      range_limit  <= RESET_RANGE_LIMIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BIN_MODE:     bin_mode     <= cfg_data[0];
        CFG_BUCKET_WIDTH: bucket_width <= cfg_data;
        CFG_RANGE_LIMIT:  range_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (req.func == FUNC_READ) ? S_FETCH : S_RUN;
          end
        end
        S_RUN: begin
          if (unit_sts.done) begin
            state <= rec_ok ? S_FETCH : S_DONE;
          end
        end
        S_FETCH: state <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Operation context and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      is_read    <= (req.func == FUNC_READ);
      cur_bucket <= req.read_index;
      read_oob   <= {1'b0, req.read_index} >= (BUCKET_W+1)'(NUM_BUCKETS);
      lin_mode   <= bin_mode;
      lin_pre_ok <= (bucket_width != '0) && (req.sample < range_limit);
    end
    if ((state == S_RUN) && unit_sts.done) begin
      cur_bucket  <= rec_bucket;
      res_counted <= 1'b0;
      res_bucket  <= '0;
      res_count   <= '0;
    end
    if (state == S_FETCH) begin
      res_counted <= 1'b1;
      res_bucket  <= cur_bucket;
      if (is_read) begin
        res_count <= read_oob ? '0 : rd_data[OUT_CNT_W-1:0];
      end else begin
        res_count <= cnt_next[OUT_CNT_W-1:0];
      end
    end
  end

  // Output register: loads the finished result once the previous one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      out_counted <= res_counted;
      out_bucket  <= res_bucket;
      out_count   <= res_count;
    end
  end

  assign req.ready        = (state == S_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.counted      = out_counted;
  assign rsp.bucket       = out_bucket;
  assign rsp.bucket_count = out_count;

endmodule

>>> src/llh_scan_div.sv
// Bit-serial unit: restoring divider that also finds leading-one positions.
module llh_scan_div import llh_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  llh_unit_ctl_t       ctl,
  input  logic [SAMPLE_W-1:0] dividend,
  input  logic [SAMPLE_W-1:0] divisor,
  input  logic [SAMPLE_W-1:0] limit,
  output llh_unit_sts_t       sts
);

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SAMPLE_W - 1);

  logic                running;
  logic                done;
  logic [STEP_W-1:0]   step;
  logic [SAMPLE_W-1:0] dvd;
  logic [SAMPLE_W-1:0] rem;
  logic [SAMPLE_W-1:0] lim_sh;
  logic [SAMPLE_W-1:0] div_q;
  logic                s_found;
  logic                l_found;
  logic [STEP_W-1:0]   s_msb;
  logic [STEP_W-1:0]   l_msb;

  logic [STEP_W-1:0]   pos;
  logic [SAMPLE_W:0]   rem_sh;
  logic [SAMPLE_W:0]   rem_diff;
  logic                q_bit;
  logic [BUCKET_W:0]   s_log;
  logic [BUCKET_W:0]   l_log;

  always_comb begin
    pos      = LAST_STEP - step;
    rem_sh   = {rem, dvd[SAMPLE_W-1]};
    rem_diff = rem_sh - {1'b0, div_q};
    q_bit    = !rem_diff[SAMPLE_W];
    s_log    = s_found ? (BUCKET_W+1)'(s_msb) : '0;
    l_log    = l_found ? (BUCKET_W+1)'(l_msb) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        running <= 1'b1;
      end else if (running && step == LAST_STEP) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dvd     <= dividend;
      div_q   <= divisor;
      lim_sh  <= limit;
      rem     <= '0;
      step    <= '0;
      s_found <= 1'b0;
      l_found <= 1'b0;
      s_msb   <= '0;
      l_msb   <= '0;
    end else if (running) begin
      if (dvd[SAMPLE_W-1] && !s_found) begin
        s_found <= 1'b1;
        s_msb   <= pos;
      end
      if (lim_sh[SAMPLE_W-1] && !l_found) begin
        l_found <= 1'b1;
        l_msb   <= pos;
      end
      rem    <= q_bit ? rem_diff[SAMPLE_W-1:0] : rem_sh[SAMPLE_W-1:0];
      dvd    <= {dvd[SAMPLE_W-2:0], q_bit};
      lim_sh <= {lim_sh[SAMPLE_W-2:0], 1'b0};
      step   <= step + 1'b1;
    end
  end

  // The log bucket must sit below floor(log2(limit)) and inside the store.
  assign sts.done       = done;
  assign sts.quotient   = dvd;
  assign sts.log_bucket = s_log[BUCKET_W-1:0];
  assign sts.log_ok     = (s_log < l_log) && (s_log < (BUCKET_W+1)'(NUM_BUCKETS));

endmodule

>>> src/llh_store.sv
// Bucket counter memory with per-entry valid bits cleared at reset.
module llh_store import llh_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  llh_store_req_t        req,
  output logic [COUNT_BITS-1:0] rd_data
);

  logic [COUNT_BITS-1:0]  mem [NUM_BUCKETS];
  logic [NUM_BUCKETS-1:0] valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= valid[req.rd_addr] ? mem[req.rd_addr] : '0;
    end
  end

endmodule
